// ===== design/mda_pkg.sv =====
// shared types and constants of the detector averager
package mda_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int SOURCES_DEF  = 16;
  localparam int SUM_BITS_DEF = 32;

  localparam logic [2:0] ACT_SAMPLE = 3'd0;
  localparam logic [2:0] ACT_ON     = 3'd1;
  localparam logic [2:0] ACT_OFF    = 3'd2;
  localparam logic [2:0] ACT_START  = 3'd3;
  localparam logic [2:0] ACT_STOP   = 3'd4;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_AVG = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [2:0] REG_SRC_COUNT = 3'd0;
  localparam logic [2:0] REG_DET_COUNT = 3'd1;
  localparam logic [2:0] REG_MASK0     = 3'd2;
  localparam logic [2:0] REG_MASK3     = 3'd5;

  localparam logic [23:0] CODE_MAX  = 24'hFFFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // request passed from front to back
  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  channel;
    logic [23:0] code;
  } req_t;

endpackage

// ===== design/mda_front.sv =====
// input stage: accepts requests, folds codes, filters and queues them
module mda_front #(
  parameter int CHANNELS = mda_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       action,
  input  logic [4:0]       channel,
  input  logic [23:0]      sample,
  output logic             q_valid,
  input  logic             q_take,
  output mda_pkg::req_t    q_head
);

  localparam int DEPTH = 4;

  mda_pkg::req_t fifo [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       keep;
  logic       push;
  logic       pop;
  mda_pkg::req_t req;

  // fold and drop requests that never matter
  always_comb begin
    req.action  = action;
    req.channel = channel;
    req.code    = sample[23] ? (mda_pkg::CODE_MAX - sample) : sample;
    keep = (action <= mda_pkg::ACT_STOP) &&
           !(action == mda_pkg::ACT_SAMPLE && 32'(channel) >= CHANNELS);
  end

  assign in_stall = (fill == 3'(DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (fill != 3'd0);
  assign pop      = q_valid && q_take;
  assign q_head   = fifo[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= req;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 3'(DEPTH))
    else $error("queue overfilled");
  a_nopop: assert property (@(posedge clk) disable iff (rst) !q_valid |-> !pop)
    else $error("pop on empty queue");
  a_push: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> fill == $past(fill) + 3'd1)
    else $error("fill miscount");

endmodule

// ===== design/mda_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
module mda_divider #(
  parameter int SUM_BITS = mda_pkg::SUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  logic [15:0]         divisor,
  output logic                done,
  output logic [23:0]         quotient
);

  localparam int CW = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0] quo;
  logic [16:0]         rem;
  logic [15:0]         dsr;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [16:0]         trial;
  logic [16:0]         diff;

  assign trial = {rem[15:0], quo[SUM_BITS-1]};
  assign diff  = trial - {1'b0, dsr};

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[16]) rem <= diff;
      else rem <= trial;
      quo <= {quo[SUM_BITS-2:0], ~diff[16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate to 24 bits
  always_comb begin
    if (SUM_BITS > 24 && (quo >> 24) != '0) quotient = mda_pkg::CODE_MAX;
    else quotient = quo[23:0];
  end

endmodule

// ===== design/mda_back.sv =====
// execution stage: accumulators, sequencing and result generation
module mda_back #(
  parameter int CHANNELS = mda_pkg::CHANNELS_DEF,
  parameter int SOURCES  = mda_pkg::SOURCES_DEF,
  parameter int SUM_BITS = mda_pkg::SUM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             q_valid,
  output logic             q_take,
  input  mda_pkg::req_t    q_head,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [3:0]       source_index,
  output logic             wavelength,
  output logic [15:0]      detector_mask,
  output logic             adc_start,
  output logic [3:0]       detector,
  output logic [7:0]       slot,
  output logic [23:0]      average,
  output logic             frame_done,
  output logic             last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;
  localparam logic [2:0] ST_CMD  = 3'd5;

  // configuration
  logic [4:0]  src_count;
  logic [4:0]  det_count;
  logic [63:0] masks [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_count <= 5'd16;
      det_count <= 5'd16;
      for (int m = 0; m < 4; m++) masks[m] <= '1;
    end else if (cfg_we) begin
      priority if (cfg_index == mda_pkg::REG_SRC_COUNT) src_count <= cfg_data[4:0];
      else if (cfg_index == mda_pkg::REG_DET_COUNT) det_count <= cfg_data[4:0];
      else if (cfg_index >= mda_pkg::REG_MASK0 && cfg_index <= mda_pkg::REG_MASK3)
        masks[2'(cfg_index - mda_pkg::REG_MASK0)] <= cfg_data;
      else ;
    end
  end

  logic [SUM_BITS-1:0] sums   [CHANNELS];
  logic [15:0]         counts [CHANNELS];
  logic [5:0] phase;
  logic       seen;
  logic [3:0] cur_src;
  logic       cur_wave;
  logic [7:0] slot_base;
  logic       running;
  logic [2:0] state;
  logic [3:0] scan;
  logic [7:0] rank;
  logic       div_start;
  logic       div_done;
  logic [23:0] div_q;
  logic [SUM_BITS-1:0] div_a;
  logic [15:0] div_b;
  logic       out_free;

  // effective source count and masks
  logic [4:0]  ns;
  logic [4:0]  dc;
  logic [4:0]  md_rem;
  logic [3:0]  new_src;
  logic [15:0] cur_mask;
  logic [15:0] new_mask;
  logic [15:0] chan_bits;
  logic [15:0] dc_bits;
  logic [6:0]  phase_inc;

  function automatic logic [15:0] src_mask(input logic [63:0] m [4], input logic [3:0] s);
    logic [63:0] r;
    r = m[s[3:2]];
    return r[{s[1:0], 4'd0} +: 16];
  endfunction

  always_comb begin
    ns = (src_count == 5'd0) ? 5'd1 : src_count;
    if (32'(ns) > SOURCES) ns = 5'(SOURCES);
    dc = (32'(det_count) > CHANNELS) ? 5'(CHANNELS) : det_count;
    // source is phase/2 modulo ns, one restoring step per bit
    md_rem = '0;
    for (int b = 5; b >= 1; b--) begin
      md_rem = {md_rem[3:0], phase[b]};
      if (md_rem >= ns) md_rem = md_rem - ns;
    end
    new_src = md_rem[3:0];
    chan_bits = 16'((17'd1 << CHANNELS) - 17'd1);
    dc_bits   = 16'((17'd1 << dc) - 17'd1);
    cur_mask = src_mask(masks, cur_src) & chan_bits;
    new_mask = src_mask(masks, new_src) & chan_bits;
    phase_inc = 7'(phase) + 7'd1;
  end

  assign out_free = !out_valid || !out_stall;
  assign q_take   = q_valid && state == ST_IDLE &&
                    (q_head.action != mda_pkg::ACT_ON || !running || out_free) &&
                    (q_head.action != mda_pkg::ACT_OFF || !running || out_free);

  logic [3:0] scan_ch;
  assign scan_ch = scan;
  assign div_a = sums[scan_ch];
  assign div_b = counts[scan_ch];

  mda_divider #(.SUM_BITS(SUM_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sums[c]   <= '0;
        counts[c] <= '0;
      end
      phase <= '0; seen <= 1'b0; cur_src <= '0; cur_wave <= 1'b0;
      slot_base <= '0; running <= 1'b0; state <= ST_IDLE; scan <= '0; rank <= '0;
      div_start <= 1'b0; out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_take) begin
            unique case (q_head.action)
              mda_pkg::ACT_SAMPLE: begin
                if (counts[q_head.channel[3:0]] != mda_pkg::COUNT_MAX) begin
                  sums[q_head.channel[3:0]] <= sums[q_head.channel[3:0]] +
                                               SUM_BITS'(q_head.code);
                  counts[q_head.channel[3:0]] <= counts[q_head.channel[3:0]] + 16'd1;
                end
              end
              mda_pkg::ACT_START: begin
                running <= 1'b1; phase <= '0; seen <= 1'b0; slot_base <= '0;
              end
              mda_pkg::ACT_STOP: running <= 1'b0;
              mda_pkg::ACT_ON: if (running) begin
                for (int c = 0; c < CHANNELS; c++) begin
                  sums[c] <= '0; counts[c] <= '0;
                end
                cur_wave <= phase[0];
                cur_src  <= new_src;
                out_valid <= 1'b1;
                kind <= mda_pkg::KIND_CMD;
                source_index <= new_src; wavelength <= phase[0];
                detector_mask <= new_mask;
                adc_start <= (new_mask & dc_bits) != '0;
                detector <= '0; slot <= '0; average <= '0;
                frame_done <= 1'b0; last <= 1'b1;
                phase <= (phase_inc >= 7'({ns, 1'b0})) ? 6'd0 : phase_inc[5:0];
                seen <= 1'b1;
              end
              mda_pkg::ACT_OFF: if (running) begin
                scan <= '0; rank <= '0;
                state <= seen ? ST_SCAN : ST_END;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (32'(scan) < CHANNELS && counts[scan_ch] != '0 && cur_mask[scan_ch]) begin
            div_start <= 1'b1;
            state <= ST_DIV;
          end else if (32'(scan) >= CHANNELS - 1) begin
            state <= ST_END;
          end else begin
            scan <= scan + 4'd1;
          end
        end
        ST_DIV: if (div_done) state <= ST_EMIT;
        ST_EMIT: if (out_free) begin
          out_valid <= 1'b1;
          kind <= mda_pkg::KIND_AVG;
          source_index <= cur_src; wavelength <= cur_wave;
          detector_mask <= '0; adc_start <= 1'b0;
          detector <= scan; slot <= slot_base + rank; average <= div_q;
          frame_done <= 1'b0; last <= 1'b0;
          sums[scan_ch] <= '0; counts[scan_ch] <= '0;
          rank <= rank + 8'd1;
          if (32'(scan) >= CHANNELS - 1) state <= ST_END;
          else begin
            scan <= scan + 4'd1;
            state <= ST_SCAN;
          end
        end
        ST_END: if (out_free) begin
          out_valid <= 1'b1;
          kind <= mda_pkg::KIND_END;
          source_index <= cur_src; wavelength <= cur_wave;
          detector_mask <= '0; adc_start <= 1'b0;
          detector <= '0; slot <= '0; average <= '0;
          frame_done <= seen && phase == '0; last <= 1'b1;
          if (seen) begin
            if (phase == '0) slot_base <= '0;
            else if (cur_wave) slot_base <= slot_base + rank;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div: assert property (@(posedge clk) disable iff (rst)
      div_start |=> state == ST_DIV)
    else $error("divider started outside divide state");
  a_take: assert property (@(posedge clk) disable iff (rst)
      q_take |-> state == ST_IDLE)
    else $error("request taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

endmodule

// ===== design/multiplexed_detector_averager_top.sv =====
// top level: front queue feeding accumulator and averaging back end
// samples, start and stop are applied by the back end in the idle state that takes them
// light-on gives its command from the idle state through the registered result output
// light-off scans channels one a cycle, pausing at each channel with an average for
// the shared divider and for output stalls
// synchronous reset clears control state, accumulators and configuration registers
module multiplexed_detector_averager_top #(
  parameter int CHANNELS = mda_pkg::CHANNELS_DEF,
  parameter int SOURCES  = mda_pkg::SOURCES_DEF,
  parameter int SUM_BITS = mda_pkg::SUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [4:0]  channel,
  input  logic [23:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [3:0]  source_index,
  output logic        wavelength,
  output logic [15:0] detector_mask,
  output logic        adc_start,
  output logic [3:0]  detector,
  output logic [7:0]  slot,
  output logic [23:0] average,
  output logic        frame_done,
  output logic        last
);

  logic          q_valid;
  logic          q_take;
  mda_pkg::req_t q_head;

  mda_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .channel(channel), .sample(sample),
    .q_valid(q_valid), .q_take(q_take), .q_head(q_head)
  );

  mda_back #(.CHANNELS(CHANNELS), .SOURCES(SOURCES), .SUM_BITS(SUM_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_take(q_take), .q_head(q_head),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .source_index(source_index), .wavelength(wavelength),
    .detector_mask(detector_mask), .adc_start(adc_start), .detector(detector),
    .slot(slot), .average(average), .frame_done(frame_done), .last(last)
  );

endmodule

// ===== bench/multiplexed_detector_averager_checker.sv =====
// checker: predicts light commands, averages and end items, compares results
`timescale 1ns / 100ps
module multiplexed_detector_averager_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  action,
  input  logic [4:0]  channel,
  input  logic [23:0] sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  source_index,
  input  logic        wavelength,
  input  logic [15:0] detector_mask,
  input  logic        adc_start,
  input  logic [3:0]  detector,
  input  logic [7:0]  slot,
  input  logic [23:0] average,
  input  logic        frame_done,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  src;
    logic        wave;
    logic [15:0] mask;
    logic        start;
    logic [3:0]  det;
    logic [7:0]  slot;
    logic [23:0] avg;
    logic        done;
    logic        last;
  } result_t;

  result_t     awaited_q[$];
  int          mismatches;

  // configuration copy
  logic [4:0]  n_src_reg;
  logic [4:0]  n_det_reg;
  logic [63:0] mask_reg [4];

  // accumulator and sequencing copy
  logic [31:0] acc_sum [16];
  logic [15:0] acc_cnt [16];
  logic [5:0]  step_no;
  logic        lit_seen;
  logic [3:0]  src_cur;
  logic        wave_cur;
  logic [7:0]  slot_first;
  logic        active;

  function automatic logic [15:0] src_mask(input logic [3:0] s);
    logic [63:0] r;
    r = mask_reg[s[3:2]] >> (32'(s[1:0]) * 16);
    return r[15:0];
  endfunction

  function automatic int eff_sources();
    int n;
    n = n_src_reg;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  // work out the results of one accepted request
  task automatic predict_request(input logic [2:0] act, input logic [4:0] ch,
                                 input logic [23:0] code);
    result_t     r;
    logic [23:0] folded;
    logic [15:0] m;
    logic [31:0] q;
    int          ns, dc, nxt, rank;
    logic        done;
    case (act)
      mda_pkg::ACT_SAMPLE: begin
        if (ch < 16 && acc_cnt[ch[3:0]] != mda_pkg::COUNT_MAX) begin
          folded = code[23] ? mda_pkg::CODE_MAX - code : code;
          acc_sum[ch[3:0]] = acc_sum[ch[3:0]] + 32'(folded);
          acc_cnt[ch[3:0]] = acc_cnt[ch[3:0]] + 16'd1;
        end
      end
      mda_pkg::ACT_START: begin
        active = 1'b1;
        step_no = '0;
        lit_seen = 1'b0;
        slot_first = '0;
      end
      mda_pkg::ACT_STOP: active = 1'b0;
      mda_pkg::ACT_ON: begin
        if (active) begin
          for (int i = 0; i < 16; i++) begin
            acc_sum[i] = '0;
            acc_cnt[i] = '0;
          end
          ns = eff_sources();
          wave_cur = step_no[0];
          src_cur = 4'((int'(step_no) >> 1) % ns);
          m = src_mask(src_cur);
          dc = n_det_reg > 16 ? 16 : int'(n_det_reg);
          r = '0;
          r.kind = mda_pkg::KIND_CMD;
          r.src = src_cur;
          r.wave = wave_cur;
          r.mask = m;
          r.start = ((32'(m) & ((32'd1 << dc) - 32'd1)) != 0);
          r.last = 1'b1;
          awaited_q.push_back(r);
          nxt = int'(step_no) + 1;
          if (nxt >= 2 * ns) nxt = 0;
          step_no = 6'(nxt);
          lit_seen = 1'b1;
        end
      end
      mda_pkg::ACT_OFF: begin
        if (active) begin
          done = 1'b0;
          if (lit_seen) begin
            m = src_mask(src_cur);
            rank = 0;
            for (int i = 0; i < 16; i++) begin
              if (acc_cnt[i] != 0 && m[i]) begin
                q = acc_sum[i] / 32'(acc_cnt[i]);
                r = '0;
                r.kind = mda_pkg::KIND_AVG;
                r.src = src_cur;
                r.wave = wave_cur;
                r.det = 4'(i);
                r.slot = 8'(int'(slot_first) + rank);
                r.avg = q > 32'(mda_pkg::CODE_MAX) ? mda_pkg::CODE_MAX : q[23:0];
                awaited_q.push_back(r);
                rank++;
                acc_sum[i] = '0;
                acc_cnt[i] = '0;
              end
            end
            if (wave_cur) slot_first = 8'(int'(slot_first) + rank);
            if (step_no == 0) begin
              done = 1'b1;
              slot_first = '0;
            end
          end
          r = '0;
          r.kind = mda_pkg::KIND_END;
          r.src = src_cur;
          r.wave = wave_cur;
          r.done = done;
          r.last = 1'b1;
          awaited_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // watch the channels, predict and compare
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      n_src_reg = 5'd16;
      n_det_reg = 5'd16;
      for (int i = 0; i < 4; i++) mask_reg[i] = '1;
      for (int i = 0; i < 16; i++) begin
        acc_sum[i] = '0;
        acc_cnt[i] = '0;
      end
      step_no = '0;
      lit_seen = 1'b0;
      src_cur = '0;
      wave_cur = 1'b0;
      slot_first = '0;
      active = 1'b0;
      awaited_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mda_pkg::REG_SRC_COUNT: n_src_reg = cfg_data[4:0];
          mda_pkg::REG_DET_COUNT: n_det_reg = cfg_data[4:0];
          default: if (cfg_index >= mda_pkg::REG_MASK0 && cfg_index <= mda_pkg::REG_MASK3)
            mask_reg[2'(cfg_index - mda_pkg::REG_MASK0)] = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) predict_request(action, channel, sample);
      if (out_valid && !out_stall) begin
        got = '{kind, source_index, wavelength, detector_mask, adc_start,
                detector, slot, average, frame_done, last};
        if (awaited_q.size() == 0) begin
          fail_count <= fail_count + 1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: %p", got);
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
    pending <= awaited_q.size();
  end

endmodule

// ===== bench/multiplexed_detector_averager_top_tb.sv =====
// testbench top: stimulus, stall generation and verdict for the averager
`timescale 1ns / 100ps
module multiplexed_detector_averager_top_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [4:0]  channel = '0;
  logic [23:0] sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  kind;
  logic [3:0]  source_index;
  logic        wavelength;
  logic [15:0] detector_mask;
  logic        adc_start;
  logic [3:0]  detector;
  logic [7:0]  slot;
  logic [23:0] average;
  logic        frame_done;
  logic        last;
  int          fail_count;
  int          pending;
  logic        no_gaps = 1'b0;

  always #6 clk = ~clk;

  multiplexed_detector_averager_top i_dut (.*);

  multiplexed_detector_averager_checker i_checker (.*);

  // result side stall, drawn per result
  initial begin
    int k;
    @(posedge clk);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 19);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request with a random gap in front
  task automatic send_request(input logic [2:0] a, input logic [4:0] c,
                              input logic [23:0] s);
    int k;
    k = no_gaps ? 0 : $urandom_range(0, 19);
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    channel <= c;
    sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results and let trailing requests settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_code();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return mda_pkg::CODE_MAX;
      2: return 24'h800000;
      3: return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one light cycle: on, a few samples, off
  task automatic light_cycle();
    int n;
    send_request(mda_pkg::ACT_ON, 5'($urandom), 24'($urandom));
    n = $urandom_range(0, 6);
    repeat (n)
      send_request(mda_pkg::ACT_SAMPLE,
                   ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 15)),
                   rand_code());
    send_request(mda_pkg::ACT_OFF, 5'($urandom), 24'($urandom));
  endtask

  initial begin
    int sc [6];
    int dcv [6];
    sc = '{1, 16, 0, 31, 3, 17};
    dcv = '{0, 16, 31, 5, 1, 12};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings
    send_request(mda_pkg::ACT_START, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_ON, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_SAMPLE, 5'd0, 24'h000000);
    send_request(mda_pkg::ACT_SAMPLE, 5'd1, mda_pkg::CODE_MAX);
    send_request(mda_pkg::ACT_SAMPLE, 5'd2, 24'h800000);
    send_request(mda_pkg::ACT_SAMPLE, 5'd3, 24'h7FFFFF);
    send_request(mda_pkg::ACT_SAMPLE, 5'd31, mda_pkg::CODE_MAX);
    send_request(mda_pkg::ACT_SAMPLE, 5'd16, 24'h123456);
    send_request(mda_pkg::ACT_SAMPLE, 5'd15, 24'hA5A5A5);
    send_request(3'd5, 5'd0, 24'd0);
    send_request(3'd6, 5'd0, 24'd0);
    send_request(3'd7, 5'd31, mda_pkg::CODE_MAX);
    send_request(mda_pkg::ACT_OFF, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_ON, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_SAMPLE, 5'd7, 24'h5A5A5A);
    send_request(mda_pkg::ACT_OFF, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_STOP, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_ON, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_OFF, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_START, 5'd0, 24'd0);
    send_request(mda_pkg::ACT_OFF, 5'd0, 24'd0);
    wait_idle();

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      no_gaps = (p == 2);
      write_reg(mda_pkg::REG_SRC_COUNT, 64'(sc[p]));
      write_reg(mda_pkg::REG_DET_COUNT, 64'(dcv[p]));
      for (int r = 0; r < 4; r++)
        write_reg(mda_pkg::REG_MASK0 + 3'(r),
                  (p == 0) ? '1 : (p == 1) ? '0 : rand_mask());
      // keep the round going on some phases to change source count mid-round
      if (p == 0 || $urandom_range(0, 2) != 0)
        send_request(mda_pkg::ACT_START, 5'd0, 24'd0);
      repeat (8) begin
        if ($urandom_range(0, 7) == 0)
          send_request(3'($urandom), 5'($urandom), rand_code());
        else
          light_cycle();
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #60000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/mda_pkg.sv
design/mda_front.sv
design/mda_divider.sv
design/mda_back.sv
design/multiplexed_detector_averager_top.sv
bench/multiplexed_detector_averager_checker.sv
bench/multiplexed_detector_averager_top_tb.sv
